@@ hdl/tcpq_pkg.sv @@
// Package with the shared types, codes and constants of the two-class priority queue.
`default_nettype none
package tcpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int KEY_BITS_DEF    = 16;
    localparam int KEY_W           = 16;
    localparam int AGE_W           = 8;
    localparam int STATUS_W        = 3;
    localparam logic [7:0] THRESHOLD_RESET = 8'd60;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SERVE  = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_LOOKUP = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_PLACE,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

@@ hdl/two_class_priority_queue_with_cancel_top.sv @@
// Top level of the two-class priority queue with cancel by id.
//
// Usage: one word on the s_ channel holds an operation (insert, serve, cancel
// or lookup), an id and an age. Exactly one result word leaves on the m_
// channel with a status, the served id, the found age and the occupancy.
// The slots live in one RAM in service order: priority entries first, then
// normal entries, each class in arrival order. The RAM has one write port
// and one registered read port, and every operation walks it one slot a cycle.
// Operation: with N entries queued, a search pass by id reads up to N slots and
// a shift pass moves up to N slots to open or close a gap. The result word is
// registered and leaves after the search pass and, by operation, a shift up
// and the place step (insert), a shift down (serve, cancel) or neither (lookup);
// an operation that fails with a status skips the shift. Items are handled one
// at a time; the next word is taken in the cycle after the result word has
// left, and a stalled receiver holds the input off until it takes the result.
// The threshold register is written over the APB port and sets the class of
// later inserts. Reset (aresetn low, synchronous) empties the queue and sets
// the threshold to 60; the RAM contents need no clearing.
`default_nettype none
module two_class_priority_queue_with_cancel_top
    import tcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [1:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_kind,
    input  wire logic [KEY_W-1:0]    s_entry_key,
    input  wire logic [AGE_W-1:0]    s_entry_age,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [KEY_W-1:0]         m_served_key,
    output logic [AGE_W-1:0]         m_found_age,
    output logic [5:0]               m_occupancy
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = KEY_BITS + AGE_W + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    state_t state_reg, state_next;
    logic [7:0] thr_reg;
    logic [CW-1:0] cnt_reg, cnt_next, pcnt_reg, pcnt_next;
    logic [CW-1:0] idx_reg, idx_next, pos_reg, pos_next;
    logic [1:0] kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [AGE_W-1:0] age_reg, age_next;
    logic found_reg, found_next, rdv_reg, rdv_next;
    logic prio_reg;
    logic out_v_reg, out_v_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [KEY_W-1:0] srv_reg, srv_next;
    logic [AGE_W-1:0] fa_reg, fa_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [RW-1:0] wdata, rdata;
    logic [KEY_BITS-1:0] rd_key;
    logic [AGE_W-1:0] rd_age;
    logic rd_prio;

    assign rd_key  = rdata[RW-1 -: KEY_BITS];
    assign rd_age  = rdata[AGE_W:1];
    assign rd_prio = rdata[0];

    tcpq_ram #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_slots (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, thr_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            thr_reg <= pwdata[7:0];
        end
    end

    assign s_ready      = (state_reg == S_IDLE) && !out_v_reg;
    assign m_valid      = out_v_reg;
    assign m_status     = st_reg;
    assign m_served_key = srv_reg;
    assign m_found_age  = fa_reg;
    assign m_occupancy  = 6'(cnt_reg);

    // Next state and datapath of the walk sequencer.
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pcnt_next = pcnt_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        age_next = age_reg;
        found_next = found_reg;
        rdv_next = 1'b0;
        out_v_next = out_v_reg;
        st_next = st_reg;
        srv_next = srv_reg;
        fa_next = fa_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        if (out_v_reg && m_ready) begin
            out_v_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    idx_next = '0;
                    found_next = 1'b0;
                    age_next = s_entry_age;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // Compare the slot read last cycle, issue the next read.
                raddr = AW'(idx_reg);
                if (rdv_reg && !found_reg && rd_key == key_reg) begin
                    found_next = 1'b1;
                    pos_next = idx_reg - 1'b1;
                    age_next = rd_age;
                end
                if (!(rdv_reg && rd_key == key_reg) && !found_reg
                        && idx_reg < cnt_reg) begin
                    rdv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    // Search complete: decide the operation.
                    state_next = S_DONE;
                    st_next = ST_OK;
                    srv_next = '0;
                    fa_next = '0;
                    unique case (kind_reg)
                        KIND_INSERT: begin
                            if (found_next) begin
                                st_next = ST_DUP;
                            end else if (cnt_reg >= DEPTH_C) begin
                                st_next = ST_FULL;
                            end else begin
                                pos_next = prio_reg ? pcnt_reg : cnt_reg;
                                idx_next = cnt_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        KIND_SERVE: begin
                            if (cnt_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else begin
                                pos_next = '0;
                                idx_next = '0;
                                raddr = '0;
                                rdv_next = 1'b1;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        KIND_CANCEL: begin
                            if (!found_next) begin
                                st_next = ST_NOT_FOUND;
                            end else begin
                                idx_next = pos_next;
                                raddr = AW'(pos_next);
                                rdv_next = 1'b1;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        default: begin
                            if (!found_next) begin
                                st_next = ST_NOT_FOUND;
                            end else begin
                                fa_next = age_next;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT_DN: begin
                // First read is the removed slot; then move slot i+1 to i.
                if (idx_reg == pos_reg && rdv_reg) begin
                    if (kind_reg == KIND_SERVE) begin
                        srv_next = KEY_W'(rd_key);
                    end
                    if (rd_prio) begin
                        pcnt_next = pcnt_reg - 1'b1;
                    end
                end
                if (idx_reg + 1'b1 < cnt_reg) begin
                    raddr = AW'(idx_reg + 1'b1);
                    if (!rdv_reg || idx_reg != pos_reg) begin
                        we = rdv_reg;
                        waddr = AW'(idx_reg - 1'b1);
                        wdata = rdata;
                    end
                    idx_next = idx_reg + 1'b1;
                    rdv_next = 1'b1;
                end else begin
                    if (idx_reg != pos_reg) begin
                        we = 1'b1;
                        waddr = AW'(idx_reg - 1'b1);
                        wdata = rdata;
                    end
                    cnt_next = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHIFT_UP: begin
                // Move slot i-1 to i, walking down to the insert position.
                if (rdv_reg) begin
                    we = 1'b1;
                    waddr = AW'(idx_reg);
                    wdata = rdata;
                    idx_next = idx_reg - 1'b1;
                end
                if (idx_next > pos_reg) begin
                    raddr = AW'(idx_next - 1'b1);
                    rdv_next = 1'b1;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                we = 1'b1;
                waddr = AW'(pos_reg);
                wdata = {key_reg, age_reg, prio_reg};
                cnt_next = cnt_reg + 1'b1;
                if (prio_reg) begin
                    pcnt_next = pcnt_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                out_v_next = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            pcnt_reg <= '0;
            out_v_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pcnt_reg <= pcnt_next;
            out_v_reg <= out_v_next;
            rdv_reg <= rdv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        found_reg <= found_next;
        st_reg <= st_next;
        srv_reg <= srv_next;
        fa_reg <= fa_next;
        age_reg <= age_next;
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            key_reg <= s_entry_key[KEY_BITS-1:0];
            prio_reg <= (s_entry_age >= thr_reg);
        end
    end

endmodule
`default_nettype wire

@@ hdl/tcpq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module tcpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
